>>> rtl/core/colsel_pkg.sv
// Shared helpers for the column top-four selector.
package colsel_pkg;

   // Index width for a count of entries, never narrower than one bit.
   function automatic int colsel_index_bits(input int count);
      int bits;
      bits = (count > 1) ? $clog2(count) : 1;
      return bits;
   endfunction

endpackage

>>> rtl/core/column_top_four_select.sv
// Column top-k selector: ranked insert of positive samples, drained on column end.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_ready    sample_value, row_index, column_end
//   rsp_     out  rsp_valid/rsp_ready    rank, found, best_value, best_row, final_rank
//
// One input word per cycle while req_ready is high: the ranked slots update in the cycle the word is taken.
// A column end copies the ranked list into a drain buffer, which gives TOP_COUNT
// result words, one per cycle while rsp_ready is high.
// A column-end word waits while the drain buffer still holds results; other words never wait.
// Synchronous active-high reset empties the slots and the drain buffer.
module column_top_four_select
   import colsel_pkg::*;
#(
   parameter int TOP_COUNT  = 4,
   parameter int ROW_COUNT  = 32,
   parameter int VALUE_BITS = 16,
   localparam int ROW_BITS  = colsel_index_bits(ROW_COUNT),
   localparam int RANK_BITS = colsel_index_bits(TOP_COUNT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_sample_value,
   input  logic        [ROW_BITS-1:0]   req_row_index,
   input  logic                         req_column_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [RANK_BITS-1:0]  rsp_rank,
   output logic                         rsp_found,
   output logic signed [VALUE_BITS-1:0] rsp_best_value,
   output logic signed [ROW_BITS:0]     rsp_best_row,
   output logic                         rsp_final_rank
);

   localparam logic [RANK_BITS-1:0] LAST_RANK = RANK_BITS'(TOP_COUNT - 1);
   // -1.0 in Q1.(VALUE_BITS-2)
   localparam logic signed [VALUE_BITS-1:0] EMPTY_VALUE =
      VALUE_BITS'(-(64'sd1 <<< (VALUE_BITS - 2)));

   // ranked slots
   logic signed [VALUE_BITS-1:0] slot_value_ff [TOP_COUNT];
   logic        [ROW_BITS-1:0]   slot_row_ff   [TOP_COUNT];
   logic        [TOP_COUNT-1:0]  slot_used_ff;
   logic signed [VALUE_BITS-1:0] slot_value_in [TOP_COUNT];
   logic        [ROW_BITS-1:0]   slot_row_in   [TOP_COUNT];
   logic        [TOP_COUNT-1:0]  slot_used_in;

   // drain buffer, shifts towards entry 0
   logic signed [VALUE_BITS-1:0] drain_value_ff [TOP_COUNT];
   logic        [ROW_BITS-1:0]   drain_row_ff   [TOP_COUNT];
   logic        [TOP_COUNT-1:0]  drain_used_ff;
   logic                         busy_ff;
   logic                         busy_in;
   logic        [RANK_BITS-1:0]  rank_ff;
   logic        [RANK_BITS-1:0]  rank_in;

   logic                 req_take;
   logic                 rsp_take;
   logic                 drain_done;
   logic                 positive;
   logic [TOP_COUNT-1:0] beats;

   assign rsp_take   = rsp_valid & rsp_ready;
   assign drain_done = rsp_take & (rank_ff == LAST_RANK);
   assign req_ready  = ~req_column_end | ~busy_ff | drain_done;
   assign req_take   = req_valid & req_ready;
   assign positive   = ~req_sample_value[VALUE_BITS-1] & (|req_sample_value);

   // new sample outranks slot i (sorted list, so this is a thermometer code)
   always_comb begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         beats[i] = ~slot_used_ff[i]
                  | (req_sample_value > slot_value_ff[i])
                  | ((req_sample_value == slot_value_ff[i])
                     & (req_row_index < slot_row_ff[i]));
      end
   end

   // ranked list after this word's insert
   always_comb begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         slot_value_in[i] = slot_value_ff[i];
         slot_row_in[i]   = slot_row_ff[i];
         slot_used_in[i]  = slot_used_ff[i];
         if (positive && beats[i]) begin
            if (i == 0 || !beats[(i > 0) ? i - 1 : 0]) begin
               slot_value_in[i] = req_sample_value;
               slot_row_in[i]   = req_row_index;
               slot_used_in[i]  = 1'b1;
            end else begin
               slot_value_in[i] = slot_value_ff[(i > 0) ? i - 1 : 0];
               slot_row_in[i]   = slot_row_ff[(i > 0) ? i - 1 : 0];
               slot_used_in[i]  = slot_used_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      rank_in = rank_ff;
      if (rsp_take) begin
         rank_in = rank_ff + 1'b1;
         if (drain_done) begin
            busy_in = 1'b0;
            rank_in = '0;
         end
      end
      if (req_take && req_column_end) begin
         busy_in = 1'b1;
         rank_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff  <= '0;
         drain_used_ff <= '0;
         busy_ff       <= 1'b0;
         rank_ff       <= '0;
      end else begin
         busy_ff <= busy_in;
         rank_ff <= rank_in;
         if (req_take) begin
            slot_used_ff <= req_column_end ? '0 : slot_used_in;
         end
         if (req_take && req_column_end) begin
            drain_used_ff <= slot_used_in;
         end else if (rsp_take) begin
            drain_used_ff <= drain_used_ff >> 1;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         if (req_take) begin
            slot_value_ff[i] <= slot_value_in[i];
            slot_row_ff[i]   <= slot_row_in[i];
         end
         if (req_take && req_column_end) begin
            drain_value_ff[i] <= slot_value_in[i];
            drain_row_ff[i]   <= slot_row_in[i];
         end else if (rsp_take && i < TOP_COUNT - 1) begin
            drain_value_ff[i] <= drain_value_ff[(i < TOP_COUNT - 1) ? i + 1 : i];
            drain_row_ff[i]   <= drain_row_ff[(i < TOP_COUNT - 1) ? i + 1 : i];
         end
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_rank       = rank_ff;
   assign rsp_found      = drain_used_ff[0];
   assign rsp_best_value = drain_used_ff[0] ? drain_value_ff[0] : EMPTY_VALUE;
   assign rsp_best_row   = drain_used_ff[0] ? {1'b0, drain_row_ff[0]} : '1;
   assign rsp_final_rank = (rank_ff == LAST_RANK);

   // rank counter sits at zero whenever nothing is draining
   a_idle_rank : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> rank_ff == '0)
      else $error("rank counter not at zero while idle");

   // a column end always starts a fresh drain at rank zero
   a_drain_start : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_column_end) |=> (rsp_valid && rsp_rank == '0))
      else $error("column end did not start a drain");

   // final word taken with no new column end leaves the output empty
   a_drain_end : assert property (@(posedge clock) disable iff (reset)
      (drain_done && !(req_take && req_column_end)) |=> !rsp_valid)
      else $error("output still valid after final rank");

   // used slots always form a prefix of the ranked list
   for (genvar g = 1; g < TOP_COUNT; g++) begin : g_prefix
      a_used_prefix : assert property (@(posedge clock) disable iff (reset)
         slot_used_ff[g] |-> slot_used_ff[g-1])
         else $error("ranked slots have a gap");
   end

endmodule

>>> tb/column_top_four_select_tb.sv
// Self-checking bench for column_top_four_select: predicts the ranked top four of each column.
module column_top_four_select_tb;

   localparam int TOP        = 4;
   localparam int VALUE_W    = 16;
   localparam int ROW_W      = 5;
   localparam int MAX_GAP    = 13;
   localparam int WORD_GOAL  = 350;
   localparam int SETTLE     = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -16'sd16384;
   localparam logic signed [ROW_W:0]     EMPTY_ROW   = -6'sd1;

   typedef struct packed {
      logic [1:0]                 rank;
      logic                       found;
      logic signed [VALUE_W-1:0]  value;
      logic signed [ROW_W:0]      row;
      logic                       final_rank;
   } rank_word_type;

   // Running top-four list of the open column and the ranked words it will give.
   class top_four_tracker_type;
      logic signed [VALUE_W-1:0] slot_value[TOP];
      logic [ROW_W-1:0]          slot_row[TOP];
      bit                        slot_used[TOP];
      rank_word_type             pending_ranks[$];
      int                        mismatches;
      int                        ranks_checked;

      function void clear_slots();
         int i;
         for (i = 0; i < TOP; i++) begin
            slot_value[i] = '0;
            slot_row[i]   = '0;
            slot_used[i]  = 1'b0;
         end
      endfunction

      function void take_sample(input logic signed [VALUE_W-1:0] v,
                                input logic [ROW_W-1:0] r, input logic col_end);
         int pos;
         int i;
         int k;
         rank_word_type w;
         if (v > 0) begin
            pos = 0;
            // walk past every held slot that ranks ahead of (or ties with) the new word
            while (pos < TOP && slot_used[pos] &&
                   !(v > slot_value[pos] || (v == slot_value[pos] && r < slot_row[pos])))
               pos++;
            if (pos < TOP) begin
               for (i = TOP - 1; i > pos; i--) begin
                  slot_value[i] = slot_value[i-1];
                  slot_row[i]   = slot_row[i-1];
                  slot_used[i]  = slot_used[i-1];
               end
               slot_value[pos] = v;
               slot_row[pos]   = r;
               slot_used[pos]  = 1'b1;
            end
         end
         if (col_end) begin
            for (k = 0; k < TOP; k++) begin
               w.rank       = k[1:0];
               w.found      = slot_used[k];
               w.value      = slot_used[k] ? slot_value[k] : EMPTY_VALUE;
               w.row        = slot_used[k] ? $signed({1'b0, slot_row[k]}) : EMPTY_ROW;
               w.final_rank = (k == TOP - 1);
               pending_ranks.push_back(w);
            end
            clear_slots();
         end
      endfunction

      function void report(input string what, input rank_word_type want,
                           input rank_word_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s: expected rank %0d found %0d value %0d row %0d final %0d",
                     what, want.rank, want.found, $signed(want.value), $signed(want.row),
                     want.final_rank);
            $display("   got rank %0d found %0d value %0d row %0d final %0d",
                     got.rank, got.found, $signed(got.value), $signed(got.row),
                     got.final_rank);
         end
      endfunction

      function void check_rank(input rank_word_type got);
         rank_word_type want;
         ranks_checked++;
         if (pending_ranks.size() == 0) begin
            report("unexpected result word", '0, got);
         end else begin
            want = pending_ranks.pop_front();
            if (got.rank !== want.rank || got.found !== want.found ||
                got.value !== want.value || got.row !== want.row ||
                got.final_rank !== want.final_rank)
               report("result mismatch", want, got);
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [VALUE_W-1:0]   req_sample_value;
   logic        [ROW_W-1:0]     req_row_index;
   logic                        req_column_end;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic        [1:0]           rsp_rank;
   logic                        rsp_found;
   logic signed [VALUE_W-1:0]   rsp_best_value;
   logic signed [ROW_W:0]       rsp_best_row;
   logic                        rsp_final_rank;

   top_four_tracker_type board;
   bit  req_idle;
   bit  rsp_idle;
   int  words_sent;
   int  columns_sent;
   int  cycle_count;

   column_top_four_select #(
      .TOP_COUNT  (TOP),
      .ROW_COUNT  (32),
      .VALUE_BITS (VALUE_W)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_row_index    (req_row_index),
      .req_column_end   (req_column_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank         (rsp_rank),
      .rsp_found        (rsp_found),
      .rsp_best_value   (rsp_best_value),
      .rsp_best_row     (rsp_best_row),
      .rsp_final_rank   (rsp_final_rank)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Input words are noted before results are checked, so a same-edge result still finds its entry.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.take_sample(req_sample_value, req_row_index, req_column_end);
         if (rsp_valid && rsp_ready)
            board.check_rank('{rsp_rank, rsp_found, rsp_best_value, rsp_best_row,
                               rsp_final_rank});
      end
   end

   task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic [ROW_W-1:0] r,
                            input logic col_end);
      int gap;
      gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_sample_value <= v;
      req_row_index    <= r;
      req_column_end   <= col_end;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (col_end)
         columns_sent++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)
         return VALUE_W'($urandom_range(1, 32767));
      else if (sel < 70)
         return VALUE_W'($urandom_range(1, 4));     // small values give plenty of ties
      else if (sel < 78)
         return ($urandom_range(0, 1) != 0) ? 16'sd32767 : 16'sd1;
      else if (sel < 88)
         return '0;
      else
         return VALUE_W'($urandom_range(32768, 65535));
   endfunction

   initial begin : rsp_side
      int gap;
      rsp_ready = 1'b0;
      forever begin
         gap = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int len;
      int j;
      board            = new;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      req_row_index    = '0;
      req_column_end   = 1'b0;
      req_idle         = 1'b1;
      rsp_idle         = 1'b1;
      board.clear_slots();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lone non-positive word carrying the column end: four empty ranks
      send_word(-16'sd32768, 5'd0, 1'b1);
      // extremes, equal values on different rows, repeated value and row
      send_word(16'sd32767, 5'd31, 1'b0);
      send_word(16'sd1, 5'd0, 1'b0);
      send_word(16'sd100, 5'd5, 1'b0);
      send_word(16'sd100, 5'd2, 1'b0);
      send_word(16'sd0, 5'd3, 1'b0);
      send_word(-16'sd1, 5'd4, 1'b0);
      send_word(16'sd200, 5'd7, 1'b0);
      send_word(16'sd200, 5'd7, 1'b1);
      // five rising values, then a smaller one: the smallest ones drop out
      send_word(16'sd5, 5'd10, 1'b0);
      send_word(16'sd6, 5'd11, 1'b0);
      send_word(16'sd7, 5'd12, 1'b0);
      send_word(16'sd8, 5'd13, 1'b0);
      send_word(16'sd9, 5'd14, 1'b0);
      send_word(16'sd4, 5'd15, 1'b1);
      // alternating bit patterns
      send_word(16'sh5555, 5'd21, 1'b0);
      send_word(16'shAAAA, 5'd10, 1'b0);
      send_word(16'sd16384, 5'd10, 1'b1);
      // two held words, column closed by a zero
      send_word(16'sd3, 5'd1, 1'b0);
      send_word(16'sd3, 5'd0, 1'b0);
      send_word(16'sd0, 5'd9, 1'b1);

      while (words_sent < WORD_GOAL) begin
         if ($urandom_range(0, 5) == 0) req_idle = !req_idle;
         if ($urandom_range(0, 5) == 0) rsp_idle = !rsp_idle;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
         for (j = 0; j < len; j++)
            send_word(pick_value(), ROW_W'($urandom_range(0, 31)), j == len - 1);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (board.pending_ranks.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d sample words in %0d columns; checked %0d ranked results.",
               words_sent, columns_sent, board.ranks_checked);
      $display("Included extreme and non-positive values, ties, slot overflow and stalls.");
      if (board.mismatches == 0 && board.pending_ranks.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", board.mismatches,
                  board.pending_ranks.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
